@@ rtl/lpp_pkg.sv @@
`timescale 1ns / 1ps

package lpp_pkg;

   localparam int DATA_W      = 8;
   localparam int DIST_W      = 17;
   localparam int VALUE_W     = 16;
   localparam int AZIM_W      = 16;
   localparam int STAMP_W     = 32;
   localparam int INDEX_W     = 6;
   localparam int STAMP_BYTES = 4;
   localparam int GREY_POS    = 16;

   localparam logic [7:0] MARKER_FIRST  = 8'hFF;
   localparam logic [7:0] MARKER_SECOND = 8'hEE;

   localparam logic [16:0] HALF_FOV_CENTIDEG = 17'd3000;
   localparam logic [5:0]  TOP_ANGLE_DECIDEG = 6'd19;

   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_STAMP   = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [2:0] CLASS_UNKNOWN = 3'd5;
   localparam logic [7:0] CLASS_LAST    = 8'd4;

   localparam logic REG_DISTANCE_MAX = 1'b0;
   localparam logic REG_DISTANCE_MIN = 1'b1;

   localparam logic [DIST_W-1:0] DISTANCE_MAX_RESET = 17'd30000;
   localparam logic [DIST_W-1:0] DISTANCE_MIN_RESET = 17'd0;

   typedef struct packed {
      logic               valid;
      logic [1:0]         kind;
      logic [INDEX_W-1:0] column;
      logic [INDEX_W-1:0] channel;
      logic [VALUE_W-1:0] value;
      logic [7:0]         amplitude;
      logic [AZIM_W-1:0]  azimuth;
      logic               grey;
      logic [STAMP_W-1:0] stamp;
   } event_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         column_index;
      logic [4:0]         channel_index;
      logic [DIST_W-1:0]  range_or_grey;
      logic               grey_mode;
      logic [7:0]         amplitude;
      logic [2:0]         channel_class;
      logic [AZIM_W-1:0]  azimuth_centideg;
      logic [16:0]        horizontal_angle_centideg;
      logic [5:0]         vertical_angle_decideg;
      logic [STAMP_W-1:0] timestamp_us;
      logic               end_of_packet;
   } result_type;

endpackage

@@ rtl/lpp_tracker.sv @@
`timescale 1ns / 1ps

module lpp_tracker #(
   parameter int HEADER_LEN = 42,
   parameter int COLUMNS    = 12,
   parameter int CHANNELS   = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [lpp_pkg::DATA_W-1:0] in_byte,
   input  logic                      in_first,
   output lpp_pkg::event_type        ev,
   input  logic                      ev_take
);
   import lpp_pkg::*;

   localparam int HDR_W = $clog2(HEADER_LEN);
   localparam int COL_W = $clog2(COLUMNS + 1);
   localparam int CH_W  = $clog2(CHANNELS + 1);

   localparam logic [HDR_W-1:0] HDR_LAST   = HDR_W'(HEADER_LEN - 1);
   localparam logic [HDR_W-1:0] GREY_AT    = HDR_W'(GREY_POS);
   localparam logic [HDR_W-1:0] STAMP_LAST = HDR_W'(STAMP_BYTES - 1);
   localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [CH_W-1:0]  CH_LAST    = CH_W'(CHANNELS - 1);

   localparam logic [1:0] SUB_MARK0 = 2'd0;
   localparam logic [1:0] SUB_MARK1 = 2'd1;
   localparam logic [1:0] SUB_AZ_LO = 2'd2;
   localparam logic [1:0] SUB_AZ_HI = 2'd3;

   localparam logic [1:0] T_LOW  = 2'd0;
   localparam logic [1:0] T_HIGH = 2'd1;
   localparam logic [1:0] T_AMP  = 2'd2;

   typedef enum logic [1:0] {PH_HEAD, PH_BODY, PH_STAMP, PH_DONE} phase_type;

   phase_type          phase_ff, phase_in;
   logic [HDR_W-1:0]   cnt_ff, cnt_in;
   logic               grey_ff, grey_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [1:0]         sub_ff, sub_in;
   logic               chan_ff, chan_in;
   logic [CH_W-1:0]    ch_ff, ch_in;
   logic [1:0]         t_ff, t_in;
   logic [7:0]         low_ff, low_in;
   logic [AZIM_W-1:0]  azim_ff, azim_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [STAMP_W-1:0] acc_ff, acc_in;
   event_type          ev_ff, ev_in;
   logic               accept;

   assign in_ready = !ev_ff.valid || ev_take;
   assign accept   = in_valid && in_ready;
   assign ev       = ev_ff;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      grey_in  = grey_ff;
      col_in   = col_ff;
      sub_in   = sub_ff;
      chan_in  = chan_ff;
      ch_in    = ch_ff;
      t_in     = t_ff;
      low_in   = low_ff;
      azim_in  = azim_ff;
      value_in = value_ff;
      acc_in   = acc_ff;
      ev_in       = ev_ff;
      ev_in.valid = ev_ff.valid && !ev_take;
      if (accept) begin
         ev_in = '0;
         if (in_first) begin
            phase_in = PH_HEAD;
            cnt_in   = '0;
            grey_in  = 1'b0;
         end
         ev_in.grey = grey_in;
         unique case (phase_in)
            PH_HEAD: begin
               if (cnt_in == GREY_AT) begin
                  grey_in = in_byte[1];
               end
               if (cnt_in == HDR_LAST) begin
                  phase_in = PH_BODY;
                  col_in   = '0;
                  sub_in   = SUB_MARK0;
                  chan_in  = 1'b0;
               end else begin
                  cnt_in = cnt_in + 1'b1;
               end
            end
            PH_BODY: begin
               if (!chan_in) begin
                  case (sub_in) inside
                     SUB_MARK0, SUB_MARK1: begin
                        if ((sub_in == SUB_MARK0 && in_byte != MARKER_FIRST) ||
                            (sub_in == SUB_MARK1 && in_byte != MARKER_SECOND)) begin
                           ev_in.valid  = 1'b1;
                           ev_in.kind   = KIND_ERROR;
                           ev_in.column = INDEX_W'(col_in);
                           phase_in     = PH_DONE;
                        end
                     end
                     SUB_AZ_LO: begin
                        low_in = in_byte;
                     end
                     default: begin
                        azim_in = {in_byte, low_in};
                        chan_in = 1'b1;
                        ch_in   = '0;
                        t_in    = T_LOW;
                     end
                  endcase
                  sub_in = sub_in + 1'b1;
               end else begin
                  case (t_in)
                     T_LOW: begin
                        low_in = in_byte;
                        t_in   = T_HIGH;
                     end
                     T_HIGH: begin
                        value_in = {in_byte, low_in};
                        t_in     = T_AMP;
                     end
                     default: begin
                        ev_in.valid     = 1'b1;
                        ev_in.kind      = KIND_CHANNEL;
                        ev_in.column    = INDEX_W'(col_in);
                        ev_in.channel   = INDEX_W'(ch_in);
                        ev_in.value     = value_in;
                        ev_in.amplitude = in_byte;
                        ev_in.azimuth   = azim_in;
                        t_in            = T_LOW;
                        if (ch_in == CH_LAST) begin
                           chan_in = 1'b0;
                           sub_in  = SUB_MARK0;
                           if (col_in == COL_LAST) begin
                              phase_in = PH_STAMP;
                              cnt_in   = '0;
                           end else begin
                              col_in = col_in + 1'b1;
                           end
                        end else begin
                           ch_in = ch_in + 1'b1;
                        end
                     end
                  endcase
               end
            end
            PH_STAMP: begin
               acc_in = (cnt_in == '0) ? STAMP_W'(in_byte) : {acc_in[STAMP_W-9:0], in_byte};
               if (cnt_in == STAMP_LAST) begin
                  ev_in.valid = 1'b1;
                  ev_in.kind  = KIND_STAMP;
                  ev_in.stamp = acc_in;
                  phase_in    = PH_DONE;
               end else begin
                  cnt_in = cnt_in + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_in_reset: begin
         end
         phase_ff    <= PH_HEAD;
         cnt_ff      <= '0;
         grey_ff     <= 1'b0;
         col_ff      <= '0;
         sub_ff      <= SUB_MARK0;
         chan_ff     <= 1'b0;
         ch_ff       <= '0;
         t_ff        <= T_LOW;
         ev_ff.valid <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         cnt_ff      <= cnt_in;
         grey_ff     <= grey_in;
         col_ff      <= col_in;
         sub_ff      <= sub_in;
         chan_ff     <= chan_in;
         ch_ff       <= ch_in;
         t_ff        <= t_in;
         ev_ff.valid <= ev_in.valid;
      end
      low_ff          <= low_in;
      azim_ff         <= azim_in;
      value_ff        <= value_in;
      acc_ff          <= acc_in;
      ev_ff.kind      <= ev_in.kind;
      ev_ff.column    <= ev_in.column;
      ev_ff.channel   <= ev_in.channel;
      ev_ff.value     <= ev_in.value;
      ev_ff.amplitude <= ev_in.amplitude;
      ev_ff.azimuth   <= ev_in.azimuth;
      ev_ff.grey      <= ev_in.grey;
      ev_ff.stamp     <= ev_in.stamp;
   end

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && in_first |=> phase_ff == PH_HEAD && cnt_ff == HDR_W'(1))
      else $error("first byte did not restart the header");

   a_error_drops: assert property (@(posedge clock) disable iff (reset)
      accept && ev_in.valid && ev_in.kind == KIND_ERROR |=> phase_ff == PH_DONE)
      else $error("bad marker did not drop the packet");

   a_stamp_ends: assert property (@(posedge clock) disable iff (reset)
      accept && ev_in.valid && ev_in.kind == KIND_STAMP |=> phase_ff == PH_DONE)
      else $error("timestamp did not end the packet");

   a_event_held: assert property (@(posedge clock) disable iff (reset)
      ev_ff.valid && !ev_take |=> ev_ff.valid && $stable(ev_ff.kind))
      else $error("pending event lost before transfer");

endmodule

@@ rtl/lpp_formatter.sv @@
`timescale 1ns / 1ps

module lpp_formatter (
   input  logic                       clock,
   input  logic                       reset,
   input  lpp_pkg::event_type         ev,
   output logic                       ev_take,
   input  logic [lpp_pkg::DIST_W-1:0] distance_max,
   input  logic [lpp_pkg::DIST_W-1:0] distance_min,
   output lpp_pkg::result_type        rsp,
   output logic                       rsp_valid,
   input  logic                       rsp_ready
);
   import lpp_pkg::*;

   logic              rsp_valid_ff;
   result_type        rsp_ff, rsp_in;
   logic [DIST_W-1:0] doubled;
   logic [DIST_W-1:0] clamped;

   assign ev_take   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign doubled   = {ev.value, 1'b0};

   always_comb begin
      clamped = doubled;
      if (clamped > distance_max) begin
         clamped = distance_max;
      end
      if (clamped < distance_min) begin
         clamped = distance_min;
      end
      rsp_in           = '0;
      rsp_in.kind      = ev.kind;
      rsp_in.grey_mode = ev.grey;
      case (ev.kind)
         KIND_CHANNEL: begin
            rsp_in.column_index     = ev.column[3:0];
            rsp_in.channel_index    = ev.channel[4:0];
            rsp_in.range_or_grey    = ev.grey ? DIST_W'(ev.value) : clamped;
            rsp_in.amplitude        = ev.amplitude;
            rsp_in.channel_class    = (ev.amplitude <= CLASS_LAST) ? ev.amplitude[2:0]
                                                                   : CLASS_UNKNOWN;
            rsp_in.azimuth_centideg = ev.azimuth;
            rsp_in.horizontal_angle_centideg = {1'b0, ev.azimuth} - HALF_FOV_CENTIDEG;
            rsp_in.vertical_angle_decideg    = TOP_ANGLE_DECIDEG - {ev.channel[4:0], 1'b0};
         end
         KIND_STAMP: begin
            rsp_in.timestamp_us  = ev.stamp;
            rsp_in.end_of_packet = 1'b1;
         end
         default: begin
            rsp_in.column_index  = ev.column[3:0];
            rsp_in.end_of_packet = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ev_take) begin
         rsp_valid_ff <= ev.valid;
      end
      if (ev_take && ev.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   a_stamp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_STAMP |-> rsp_ff.end_of_packet)
      else $error("timestamp result without end of packet");

   a_channel_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.kind == KIND_CHANNEL |-> !rsp_ff.end_of_packet)
      else $error("channel result marked as end of packet");

   a_clamp_bounds: assert property (@(posedge clock) disable iff (reset)
      ev_take && ev.valid && ev.kind == KIND_CHANNEL && !ev.grey
         && distance_min <= distance_max
      |=> rsp_ff.range_or_grey <= $past(distance_max)
          && rsp_ff.range_or_grey >= $past(distance_min))
      else $error("distance outside configured limits");

endmodule

@@ rtl/lidar_packet_parser_core.sv @@
`timescale 1ns / 1ps

// Byte-serial parser for fixed-length lidar data packets. One packet byte is taken per cycle as
// a transfer on the req_ channel, with req_tuser set on the first byte of a packet. One result
// comes out per channel (on its amplitude byte), one for the timestamp, and one for a bad column
// marker, after which the rest of that packet is dropped and downstream must discard its channels.
// A position tracker register and a result register sit between the two sides, so req_tready stays
// high while either is free and a byte can be taken every cycle unless both hold results that
// rsp_tready has not yet taken. The distance limits are written through the csr_ port; the user
// must write them only while the block is idle, which the block itself does not enforce.

module lidar_packet_parser_core #(
   parameter int HEADER_LEN = 42,
   parameter int COLUMNS    = 12,
   parameter int CHANNELS   = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,  // data_byte
   input  logic                       req_tuser,  // first_byte
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // column_index, channel_index, range_or_grey, grey_mode, amplitude, channel_class,
   // azimuth_centideg, horizontal_angle_centideg, vertical_angle_decideg, timestamp_us
   output logic [111:0]               rsp_tdata,
   output logic [1:0]                 rsp_tuser,  // kind
   output logic                       rsp_tlast,  // end_of_packet
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [lpp_pkg::DIST_W-1:0] csr_wdata
);
   import lpp_pkg::*;

   logic [DIST_W-1:0] dist_max_ff;
   logic [DIST_W-1:0] dist_min_ff;
   event_type         ev;
   logic              ev_take;
   result_type        rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_max_ff <= DISTANCE_MAX_RESET;
         dist_min_ff <= DISTANCE_MIN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_DISTANCE_MAX: dist_max_ff <= csr_wdata;
            REG_DISTANCE_MIN: dist_min_ff <= csr_wdata;
         endcase
      end
   end

   lpp_tracker #(
      .HEADER_LEN (HEADER_LEN),
      .COLUMNS    (COLUMNS),
      .CHANNELS   (CHANNELS)
   ) u_tracker (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_first (req_tuser),
      .ev       (ev),
      .ev_take  (ev_take)
   );

   lpp_formatter u_formatter (
      .clock        (clock),
      .reset        (reset),
      .ev           (ev),
      .ev_take      (ev_take),
      .distance_max (dist_max_ff),
      .distance_min (dist_min_ff),
      .rsp          (rsp),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.end_of_packet;
   assign rsp_tdata = {3'b000,
                       rsp.timestamp_us,
                       rsp.vertical_angle_decideg,
                       rsp.horizontal_angle_centideg,
                       rsp.azimuth_centideg,
                       rsp.channel_class,
                       rsp.amplitude,
                       rsp.grey_mode,
                       rsp.range_or_grey,
                       rsp.channel_index,
                       rsp.column_index};

endmodule
